FILE: rtl/stfe_pkg.sv
// Shared constants, training ROM tables and helper functions for the spike threshold extractor.
package stfe_pkg;

  // Block dimensions.
  localparam int CHANNELS    = 64;
  localparam int LEVELS      = 3;
  localparam int COUNT_WIDTH = 12;

  // Port field widths.
  localparam int CH_IN_W    = 6;
  localparam int SAMPLE_W   = 16;
  localparam int FIDX_W     = 8;
  localparam int FVAL_W     = 16;
  localparam int SIGMA_W    = 8;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA_MID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA_HIGH = 2'd2;
  localparam int SIGMA_REGS = 3;

  localparam logic [SIGMA_W-1:0] SIGMA_LOW_RESET  = 8'd48;
  localparam logic [SIGMA_W-1:0] SIGMA_MID_RESET  = 8'd64;
  localparam logic [SIGMA_W-1:0] SIGMA_HIGH_RESET = 8'd80;

  // Derived widths.
  localparam int CH_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ROW_W   = LEVELS * COUNT_WIDTH;
  localparam int MAG_W   = SAMPLE_W + 1;
  localparam int THR_W   = SIGMA_W + 16;
  localparam int DIFF_W  = COUNT_WIDTH + 9;
  localparam int PROD_W  = DIFF_W + 17;
  localparam int Q_W     = PROD_W - 16;

  // First feature index that carries the last level of a run.
  localparam logic [FIDX_W-1:0] LAST_BASE = FIDX_W'((LEVELS - 1) * CHANNELS);

  // Training tables cover 64 channels and 3 levels.
  localparam int ROM_CH     = 64;
  localparam int ROM_LV     = 3;
  localparam int ROM_CH_W   = 6;
  localparam int ROM_ADDR_W = 8;

  localparam longint QI_NUM = 64'd65536000000;

  typedef logic [LEVELS-1:0][COUNT_WIDTH-1:0] count_row_t;

  // Micro-units to Q8.8, rounded to nearest.
  function automatic logic [15:0] qd(input longint u);
    return 16'((u * 256 + 500000) / 1000000);
  endfunction

  // Table address for a level and channel; levels above the trained ones reuse the top level.
  function automatic logic [ROM_ADDR_W-1:0] rom_addr(input logic [LVL_W-1:0] lvl,
                                                     input logic [CH_IN_W-1:0] ch);
    int l;
    l = (int'(lvl) < ROM_LV) ? int'(lvl) : ROM_LV - 1;
    return ROM_ADDR_W'(l * ROM_CH + int'(ch[ROM_CH_W-1:0]));
  endfunction

  localparam logic [15:0] DEV_ROM [ROM_CH] = '{
    qd(20298405), qd(22462172), qd(21739756), qd(25051172),
    qd(19765423), qd(20307899), qd(25570288), qd(21579393),
    qd(22996510), qd(24847061), qd(23753981), qd(21673481),
    qd(25781212), qd(24577623), qd(19569157), qd(22714901),
    qd(22350138), qd(25650391), qd(25125837), qd(20648691),
    qd(22774551), qd(25506161), qd(26347424), qd(25485119),
    qd(21127657), qd(22593182), qd(20331587), qd(23872692),
    qd(24270782), qd(22835041), qd(21272261), qd(20669004),
    qd(23986588), qd(25591860), qd(23556793), qd(19685074),
    qd(20843586), qd(24842119), qd(25459375), qd(24482803),
    qd(23969755), qd(23472115), qd(19928993), qd(24721952),
    qd(25802179), qd(19781519), qd(23407574), qd(24860622),
    qd(19330820), qd(22719198), qd(22345249), qd(24027863),
    qd(22243345), qd(24570818), qd(26009296), qd(24696100),
    qd(21563696), qd(23315105), qd(23492218), qd(24907070),
    qd(22085670), qd(21834814), qd(25990767), qd(20744581)
  };

  localparam logic [15:0] MEAN_ROM [ROM_CH*ROM_LV] = '{
    qd(15685611), qd(26608480), qd(23329424), qd(38542477),
    qd(13320252), qd(15976094), qd(40938656), qd(22171854),
    qd(29305819), qd(37691025), qd(32667419), qd(22849045),
    qd(41961060), qd(36480377), qd(12381597), qd(27800482),
    qd(26202677), qd(41447754), qd(38862125), qd(17458878),
    qd(27990828), qd(40774620), qd(43872803), qd(40562172),
    qd(20138475), qd(27400541), qd(16025410), qd(33355286),
    qd(35358894), qd(28532251), qd(20884228), qd(17721996),
    qd(34021049), qd(41141483), qd(31762291), qd(12846790),
    qd(18764997), qd(37829197), qd(40622913), qd(36219517),
    qd(33918961), qd(31355434), qd(14088408), qd(37284317),
    qd(41995789), qd(13466997), qd(31181326), qd(37839874),
    qd(11202676), qd(28046459), qd(26009022), qd(33990829),
    qd(25752970), qd(36578861), qd(42781837), qd(37159676),
    qd(21963163), qd(30865284), qd(31672981), qd(37853405),
    qd(24871599), qd(23775221), qd(42706360), qd(18063900),
    qd(10333784), qd(18261013), qd(16025410), qd(25402346),
    qd(8321606),  qd(10631333), qd(26778229), qd(15274395),
    qd(19987070), qd(24838671), qd(22005262), qd(15703653),
    qd(27309877), qd(24193956), qd(7655089),  qd(19005413),
    qd(18009022), qd(27046761), qd(25607277), qd(11797925),
    qd(19113216), qd(26684710), qd(28490904), qd(26562773),
    qd(13777778), qd(18741993), qd(10712073), qd(22386257),
    qd(23585627), qd(19481131), qd(14301609), qd(11987370),
    qd(22749962), qd(26841827), qd(21420538), qd(8015036),
    qd(12807398), qd(24988123), qd(26555405), qd(24063900),
    qd(22741241), qd(21225531), qd(9122538),  qd(24690271),
    qd(27352428), qd(8553601),  qd(21112764), qd(24950384),
    qd(6603669),  qd(19179371), qd(17844835), qd(22724703),
    qd(17584423), qd(24263119), qd(27791309), qd(24568186),
    qd(15038190), qd(20915953), qd(21390467), qd(25016388),
    qd(17058939), qd(16362202), qd(27782740), qd(12276650),
    qd(7627424),  qd(13115622), qd(11476019), qd(18956697),
    qd(6233499),  qd(7787400),  qd(20307472), qd(10983461),
    qd(14400241), qd(18543528), qd(16044655), qd(11298451),
    qd(20755676), qd(17928581), qd(5738986),  qd(13694933),
    qd(12894301), qd(20560968), qd(19192753), qd(8598256),
    qd(13786198), qd(20163584), qd(22047060), qd(20092617),
    qd(9958954),  qd(13464441), qd(7835664),  qd(16297850),
    qd(17285521), qd(13989926), qd(10319050), qd(8698091),
    qd(16622913), qd(20367764), qd(15577207), qd(5996241),
    qd(9269584),  qd(18651781), qd(20094271), qd(17811007),
    qd(16604271), qd(15389265), qd(6751165),  qd(18341602),
    qd(20852955), qd(6362652),  qd(15285069), qd(18597204),
    qd(5010976),  qd(13757480), qd(12826643), qd(16648624),
    qd(12662758), qd(18003910), qd(21298151), qd(18245678),
    qd(10864983), qd(15134416), qd(15488197), qd(18627424),
    qd(12267930), qd(11708916), qd(21293640), qd(8896256)
  };

  // Reciprocal deviations in Q0.16, rounded to nearest.
  localparam logic [15:0] INV_ROM [ROM_CH*ROM_LV] = '{
    16'((QI_NUM + 18191763 / 2) / 18191763), 16'((QI_NUM + 20244968 / 2) / 20244968),
    16'((QI_NUM + 19546118 / 2) / 19546118), 16'((QI_NUM + 21780008 / 2) / 21780008),
    16'((QI_NUM + 16925415 / 2) / 16925415), 16'((QI_NUM + 17365368 / 2) / 17365368),
    16'((QI_NUM + 21177618 / 2) / 21177618), 16'((QI_NUM + 20224771 / 2) / 20224771),
    16'((QI_NUM + 20438295 / 2) / 20438295), 16'((QI_NUM + 21930269 / 2) / 21930269),
    16'((QI_NUM + 21179695 / 2) / 21179695), 16'((QI_NUM + 19591692 / 2) / 19591692),
    16'((QI_NUM + 21828548 / 2) / 21828548), 16'((QI_NUM + 22969292 / 2) / 22969292),
    16'((QI_NUM + 15422401 / 2) / 15422401), 16'((QI_NUM + 21149147 / 2) / 21149147),
    16'((QI_NUM + 20286938 / 2) / 20286938), 16'((QI_NUM + 21253248 / 2) / 21253248),
    16'((QI_NUM + 21969234 / 2) / 21969234), 16'((QI_NUM + 18089228 / 2) / 18089228),
    16'((QI_NUM + 22952213 / 2) / 22952213), 16'((QI_NUM + 21771219 / 2) / 21771219),
    16'((QI_NUM + 21457684 / 2) / 21457684), 16'((QI_NUM + 21828251 / 2) / 21828251),
    16'((QI_NUM + 19031542 / 2) / 19031542), 16'((QI_NUM + 21259468 / 2) / 21259468),
    16'((QI_NUM + 18069740 / 2) / 18069740), 16'((QI_NUM + 21133158 / 2) / 21133158),
    16'((QI_NUM + 21509619 / 2) / 21509619), 16'((QI_NUM + 20265467 / 2) / 20265467),
    16'((QI_NUM + 19803974 / 2) / 19803974), 16'((QI_NUM + 17809914 / 2) / 17809914),
    16'((QI_NUM + 22968887 / 2) / 22968887), 16'((QI_NUM + 21598808 / 2) / 21598808),
    16'((QI_NUM + 22355989 / 2) / 22355989), 16'((QI_NUM + 15909631 / 2) / 15909631),
    16'((QI_NUM + 18886637 / 2) / 18886637), 16'((QI_NUM + 21482899 / 2) / 21482899),
    16'((QI_NUM + 21468498 / 2) / 21468498), 16'((QI_NUM + 22618111 / 2) / 22618111),
    16'((QI_NUM + 21605556 / 2) / 21605556), 16'((QI_NUM + 21928602 / 2) / 21928602),
    16'((QI_NUM + 16836626 / 2) / 16836626), 16'((QI_NUM + 21929855 / 2) / 21929855),
    16'((QI_NUM + 22115938 / 2) / 22115938), 16'((QI_NUM + 16282793 / 2) / 16282793),
    16'((QI_NUM + 21008196 / 2) / 21008196), 16'((QI_NUM + 22103706 / 2) / 22103706),
    16'((QI_NUM + 14593416 / 2) / 14593416), 16'((QI_NUM + 20620222 / 2) / 20620222),
    16'((QI_NUM + 20135286 / 2) / 20135286), 16'((QI_NUM + 23551311 / 2) / 23551311),
    16'((QI_NUM + 20698746 / 2) / 20698746), 16'((QI_NUM + 22340530 / 2) / 22340530),
    16'((QI_NUM + 21584255 / 2) / 21584255), 16'((QI_NUM + 21792974 / 2) / 21792974),
    16'((QI_NUM + 21297247 / 2) / 21297247), 16'((QI_NUM + 20777351 / 2) / 20777351),
    16'((QI_NUM + 21789530 / 2) / 21789530), 16'((QI_NUM + 21658014 / 2) / 21658014),
    16'((QI_NUM + 21408495 / 2) / 21408495), 16'((QI_NUM + 19772276 / 2) / 19772276),
    16'((QI_NUM + 21563169 / 2) / 21563169), 16'((QI_NUM + 18470993 / 2) / 18470993),
    16'((QI_NUM + 13594925 / 2) / 13594925), 16'((QI_NUM + 14713108 / 2) / 14713108),
    16'((QI_NUM + 14304099 / 2) / 14304099), 16'((QI_NUM + 15001314 / 2) / 15001314),
    16'((QI_NUM + 12793591 / 2) / 12793591), 16'((QI_NUM + 13004782 / 2) / 13004782),
    16'((QI_NUM + 14492745 / 2) / 14492745), 16'((QI_NUM + 14749949 / 2) / 14749949),
    16'((QI_NUM + 14694764 / 2) / 14694764), 16'((QI_NUM + 15094151 / 2) / 15094151),
    16'((QI_NUM + 14973563 / 2) / 14973563), 16'((QI_NUM + 14382947 / 2) / 14382947),
    16'((QI_NUM + 14873932 / 2) / 14873932), 16'((QI_NUM + 15829131 / 2) / 15829131),
    16'((QI_NUM + 11840421 / 2) / 11840421), 16'((QI_NUM + 15128487 / 2) / 15128487),
    16'((QI_NUM + 14708593 / 2) / 14708593), 16'((QI_NUM + 14621587 / 2) / 14621587),
    16'((QI_NUM + 15133408 / 2) / 15133408), 16'((QI_NUM + 13515504 / 2) / 13515504),
    16'((QI_NUM + 16285362 / 2) / 16285362), 16'((QI_NUM + 14937003 / 2) / 14937003),
    16'((QI_NUM + 14659839 / 2) / 14659839), 16'((QI_NUM + 14974978 / 2) / 14974978),
    16'((QI_NUM + 14044764 / 2) / 14044764), 16'((QI_NUM + 15235609 / 2) / 15235609),
    16'((QI_NUM + 13657270 / 2) / 13657270), 16'((QI_NUM + 14922446 / 2) / 14922446),
    16'((QI_NUM + 15108807 / 2) / 15108807), 16'((QI_NUM + 14564578 / 2) / 14564578),
    16'((QI_NUM + 14461169 / 2) / 14461169), 16'((QI_NUM + 13288880 / 2) / 13288880),
    16'((QI_NUM + 15942496 / 2) / 15942496), 16'((QI_NUM + 14819059 / 2) / 14819059),
    16'((QI_NUM + 15689116 / 2) / 15689116), 16'((QI_NUM + 12088410 / 2) / 12088410),
    16'((QI_NUM + 14043472 / 2) / 14043472), 16'((QI_NUM + 14840352 / 2) / 14840352),
    16'((QI_NUM + 14662546 / 2) / 14662546), 16'((QI_NUM + 15678202 / 2) / 15678202),
    16'((QI_NUM + 15155654 / 2) / 15155654), 16'((QI_NUM + 15444760 / 2) / 15444760),
    16'((QI_NUM + 12784846 / 2) / 12784846), 16'((QI_NUM + 15212642 / 2) / 15212642),
    16'((QI_NUM + 15066474 / 2) / 15066474), 16'((QI_NUM + 12426658 / 2) / 12426658),
    16'((QI_NUM + 14840106 / 2) / 14840106), 16'((QI_NUM + 15266517 / 2) / 15266517),
    16'((QI_NUM + 11372702 / 2) / 11372702), 16'((QI_NUM + 14854069 / 2) / 14854069),
    16'((QI_NUM + 14563771 / 2) / 14563771), 16'((QI_NUM + 16258026 / 2) / 16258026),
    16'((QI_NUM + 14905855 / 2) / 14905855), 16'((QI_NUM + 15443290 / 2) / 15443290),
    16'((QI_NUM + 14699476 / 2) / 14699476), 16'((QI_NUM + 15081415 / 2) / 15081415),
    16'((QI_NUM + 15459086 / 2) / 15459086), 16'((QI_NUM + 14839217 / 2) / 14839217),
    16'((QI_NUM + 15339760 / 2) / 15339760), 16'((QI_NUM + 14988008 / 2) / 14988008),
    16'((QI_NUM + 15440960 / 2) / 15440960), 16'((QI_NUM + 14430024 / 2) / 14430024),
    16'((QI_NUM + 14668025 / 2) / 14668025), 16'((QI_NUM + 13757895 / 2) / 13757895),
    16'((QI_NUM + 10661610 / 2) / 10661610), 16'((QI_NUM + 11118814 / 2) / 11118814),
    16'((QI_NUM + 10920627 / 2) / 10920627), 16'((QI_NUM + 11549815 / 2) / 11549815),
    16'((QI_NUM + 10213261 / 2) / 10213261), 16'((QI_NUM + 10217992 / 2) / 10217992),
    16'((QI_NUM + 11281211 / 2) / 11281211), 16'((QI_NUM + 11224424 / 2) / 11224424),
    16'((QI_NUM + 11116843 / 2) / 11116843), 16'((QI_NUM + 11696676 / 2) / 11696676),
    16'((QI_NUM + 11402411 / 2) / 11402411), 16'((QI_NUM + 10994255 / 2) / 10994255),
    16'((QI_NUM + 11582550 / 2) / 11582550), 16'((QI_NUM + 12098734 / 2) / 12098734),
    16'((QI_NUM + 9567594 / 2) / 9567594),   16'((QI_NUM + 11437461 / 2) / 11437461),
    16'((QI_NUM + 11145898 / 2) / 11145898), 16'((QI_NUM + 11447211 / 2) / 11447211),
    16'((QI_NUM + 11649822 / 2) / 11649822), 16'((QI_NUM + 10488624 / 2) / 10488624),
    16'((QI_NUM + 12257290 / 2) / 12257290), 16'((QI_NUM + 11604843 / 2) / 11604843),
    16'((QI_NUM + 11615788 / 2) / 11615788), 16'((QI_NUM + 11647099 / 2) / 11647099),
    16'((QI_NUM + 10821732 / 2) / 10821732), 16'((QI_NUM + 11484796 / 2) / 11484796),
    16'((QI_NUM + 10675017 / 2) / 10675017), 16'((QI_NUM + 11359497 / 2) / 11359497),
    16'((QI_NUM + 11491159 / 2) / 11491159), 16'((QI_NUM + 11042858 / 2) / 11042858),
    16'((QI_NUM + 11027085 / 2) / 11027085), 16'((QI_NUM + 10331665 / 2) / 10331665),
    16'((QI_NUM + 12058995 / 2) / 12058995), 16'((QI_NUM + 11557966 / 2) / 11557966),
    16'((QI_NUM + 11918956 / 2) / 11918956), 16'((QI_NUM + 9719776 / 2) / 9719776),
    16'((QI_NUM + 10827259 / 2) / 10827259), 16'((QI_NUM + 11486478 / 2) / 11486478),
    16'((QI_NUM + 11430188 / 2) / 11430188), 16'((QI_NUM + 12000022 / 2) / 12000022),
    16'((QI_NUM + 11520167 / 2) / 11520167), 16'((QI_NUM + 11747769 / 2) / 11747769),
    16'((QI_NUM + 10183382 / 2) / 10183382), 16'((QI_NUM + 11654526 / 2) / 11654526),
    16'((QI_NUM + 11766397 / 2) / 11766397), 16'((QI_NUM + 9952143 / 2) / 9952143),
    16'((QI_NUM + 11285550 / 2) / 11285550), 16'((QI_NUM + 11715734 / 2) / 11715734),
    16'((QI_NUM + 9356391 / 2) / 9356391),   16'((QI_NUM + 11189957 / 2) / 11189957),
    16'((QI_NUM + 11071066 / 2) / 11071066), 16'((QI_NUM + 12333899 / 2) / 12333899),
    16'((QI_NUM + 11262832 / 2) / 11262832), 16'((QI_NUM + 11791668 / 2) / 11791668),
    16'((QI_NUM + 11475060 / 2) / 11475060), 16'((QI_NUM + 11662204 / 2) / 11662204),
    16'((QI_NUM + 11740227 / 2) / 11740227), 16'((QI_NUM + 11251074 / 2) / 11251074),
    16'((QI_NUM + 11594770 / 2) / 11594770), 16'((QI_NUM + 11589977 / 2) / 11589977),
    16'((QI_NUM + 11705737 / 2) / 11705737), 16'((QI_NUM + 10932086 / 2) / 10932086),
    16'((QI_NUM + 11461974 / 2) / 11461974), 16'((QI_NUM + 10619514 / 2) / 10619514)
  };

endpackage

FILE: rtl/spike_threshold_feature_extractor_core.sv
// Top level of the multi-threshold spike crossing counter with z-score feature output.
//
//   Channel   Handshake            Payload                                  Beat
//   -------   ------------------   --------------------------------------   -------------------
//   in        in_valid / in_stall  channel, sample, bin_end                 one sample
//   out       out_valid/out_stall  feature_index, feature_value, last_of_run one feature
//   cfg       cfg_write            cfg_index, cfg_data                      one register write
//
// Samples that do not end a bin are taken one per cycle unless a bin-end beat waits at
// the update stage. A bin-end beat yields LEVELS output beats, one per cycle while the
// output is not stalled; the next bin-end beat waits until the last level issues, since
// the single shared z-score multiplier serves all levels. Reset clears the row valid bits,
// so input is taken right after reset with no clearing pass. Output stalls back up the
// feature pipeline; a bin-end beat then waits at the update stage and holds the input.
module spike_threshold_feature_extractor_core
  import stfe_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  // Sample input.
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [CH_IN_W-1:0]         channel,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       bin_end,
  // Feature output.
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [FIDX_W-1:0]          feature_index,
  output logic signed [FVAL_W-1:0]   feature_value,
  output logic                       last_of_run,
  // Configuration writes.
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [SIGMA_W-1:0]         cfg_data
);

  // ---------------------------------------------------------------------------
  // Sigma level registers (unsigned Q4.4).
  // ---------------------------------------------------------------------------
  logic [SIGMA_W-1:0] sigma [SIGMA_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma[0] <= SIGMA_LOW_RESET;
      sigma[1] <= SIGMA_MID_RESET;
      sigma[2] <= SIGMA_HIGH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SIGMA_LOW:  sigma[0] <= cfg_data;
        REG_SIGMA_MID:  sigma[1] <= cfg_data;
        REG_SIGMA_HIGH: sigma[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Accept stage: threshold compare against the live sample, counter row read.
  // The threshold is sigma times the channel deviation, both Q.12 after the
  // multiply; the magnitude is shifted up by eight bits to line up with it.
  // ---------------------------------------------------------------------------
  logic                  in_take;
  logic                  in_range;
  logic [MAG_W-1:0]      mag;
  logic [15:0]           dev;
  logic [LEVELS-1:0]     hit;
  logic [CH_AW-1:0]      in_addr;

  always_comb begin
    in_take  = in_valid && !in_stall;
    in_range = int'(channel) < CHANNELS;
    in_addr  = CH_AW'(channel);
    mag      = sample[SAMPLE_W-1] ? (MAG_W'(1 << SAMPLE_W) - {1'b0, sample})
                                  : {1'b0, sample};
    dev      = DEV_ROM[channel[ROM_CH_W-1:0]];
    for (int l = 0; l < LEVELS; l++) begin
      logic [THR_W-1:0] thr;
      thr    = sigma[(l < SIGMA_REGS) ? l : SIGMA_REGS - 1] * dev;
      hit[l] = {mag, 8'd0} > {1'b0, thr};
    end
  end

  // Counter store: one row per channel holding every level's count.
  logic              ram_we;
  logic [CH_AW-1:0]  ram_waddr;
  count_row_t        ram_wdata;
  logic [ROW_W-1:0]  ram_rdata;

  stfe_ram #(
    .WIDTH (ROW_W),
    .DEPTH (CHANNELS)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (in_take),
    .rd_addr (in_addr),
    .rd_data (ram_rdata)
  );

  // A row that has never been written reads as zero.
  logic [CHANNELS-1:0] row_valid;

  // ---------------------------------------------------------------------------
  // Update stage: merge the read row with a forwarded write, bump the counters
  // and write the row back (zeroed when the bin closes).
  // ---------------------------------------------------------------------------
  logic                 s1_valid;
  logic                 s1_in_range;
  logic                 s1_bin_end;
  logic [CH_IN_W-1:0]   s1_ch;
  logic [LEVELS-1:0]    s1_hit;
  logic                 s1_row_ok;
  logic                 s1_fwd;
  count_row_t           s1_fwd_row;

  logic                 s1_go;
  logic                 job_free;
  logic                 job_load;
  count_row_t           cur_row;
  count_row_t           new_row;

  always_comb begin
    if (s1_fwd) begin
      cur_row = s1_fwd_row;
    end else if (s1_row_ok) begin
      cur_row = count_row_t'(ram_rdata);
    end else begin
      cur_row = '0;
    end
    for (int l = 0; l < LEVELS; l++) begin
      new_row[l] = cur_row[l] + COUNT_WIDTH'(s1_hit[l] && (cur_row[l] != '1));
    end
    // Only an in-range bin-end beat needs the feature unit; everything else retires at once.
    s1_go     = !s1_bin_end || !s1_in_range || job_free;
    in_stall  = s1_valid && !s1_go;
    ram_we    = s1_valid && s1_in_range && s1_go;
    ram_waddr = CH_AW'(s1_ch);
    ram_wdata = s1_bin_end ? '0 : new_row;
    job_load  = ram_we && s1_bin_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      row_valid <= '0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (ram_we) begin
        row_valid[ram_waddr] <= 1'b1;
      end
    end
  end

  // The row written back in the same cycle as a new read of that row is
  // forwarded, since the memory returns the old contents.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_in_range <= in_range;
      s1_bin_end  <= bin_end;
      s1_ch       <= channel;
      s1_hit      <= hit;
      s1_row_ok   <= row_valid[in_addr];
      s1_fwd      <= ram_we && (ram_waddr == in_addr);
      s1_fwd_row  <= ram_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Feature sequencer: walks the levels of one finished bin, one per cycle unless stalled.
  // ---------------------------------------------------------------------------
  logic                  job_busy;
  logic [LVL_W-1:0]      job_lvl;
  logic [CH_IN_W-1:0]    job_ch;
  count_row_t            job_cnt;
  logic                  job_issue;
  logic                  job_last;

  logic                  e1_valid;
  logic signed [DIFF_W-1:0] e1_diff;
  logic [15:0]           e1_inv;
  logic [FIDX_W-1:0]     e1_index;
  logic                  e1_last;

  logic                  e2_valid;
  logic signed [PROD_W-1:0] e2_prod;
  logic [FIDX_W-1:0]     e2_index;
  logic                  e2_last;

  logic                  out_rdy;
  logic                  e2_rdy;
  logic                  e1_rdy;

  always_comb begin
    out_rdy   = !out_valid || !out_stall;
    e2_rdy    = !e2_valid || out_rdy;
    e1_rdy    = !e1_valid || e2_rdy;
    job_issue = job_busy && e1_rdy;
    job_last  = int'(job_lvl) == LEVELS - 1;
    job_free  = !job_busy || (job_issue && job_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_busy <= 1'b0;
    end else if (job_load) begin
      job_busy <= 1'b1;
    end else if (job_issue && job_last) begin
      job_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job_lvl <= '0;
      job_ch  <= s1_ch;
      job_cnt <= new_row;
    end else if (job_issue && !job_last) begin
      job_lvl <= job_lvl + 1'b1;
    end
  end

  // Stage one: difference against the training mean and reciprocal lookup.
  logic [ROM_ADDR_W-1:0] rom_a;
  logic [COUNT_WIDTH-1:0] cnt_sel;

  always_comb begin
    rom_a   = rom_addr(job_lvl, job_ch);
    cnt_sel = job_cnt[job_lvl];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid <= 1'b0;
    end else if (e1_rdy) begin
      e1_valid <= job_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (job_issue) begin
      e1_diff  <= DIFF_W'({1'b0, cnt_sel, 8'd0}) - DIFF_W'(MEAN_ROM[rom_a]);
      e1_inv   <= INV_ROM[rom_a];
      e1_index <= FIDX_W'(int'(job_lvl) * CHANNELS + int'(job_ch));
      e1_last  <= job_last;
    end
  end

  // Stage two: Q.8 difference times Q0.16 reciprocal gives Q.24.
  always_ff @(posedge clk) begin
    if (rst) begin
      e2_valid <= 1'b0;
    end else if (e2_rdy) begin
      e2_valid <= e1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (e1_valid && e2_rdy) begin
      e2_prod  <= PROD_W'(e1_diff) * PROD_W'($signed({1'b0, e1_inv}));
      e2_index <= e1_index;
      e2_last  <= e1_last;
    end
  end

  // Stage three: round half up to Q7.8 and saturate into the output register.
  logic signed [PROD_W-1:0] rnd_sum;
  logic signed [Q_W-1:0]    rnd_q;
  logic [FVAL_W-1:0]        sat_val;

  always_comb begin
    rnd_sum = e2_prod + PROD_W'(32768);
    rnd_q   = rnd_sum[PROD_W-1:16];
    if (rnd_q > $signed(Q_W'(32767))) begin
      sat_val = 16'h7FFF;
    end else if (rnd_q < -$signed(Q_W'(32768))) begin
      sat_val = 16'h8000;
    end else begin
      sat_val = rnd_q[FVAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_rdy) begin
      out_valid <= e2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (e2_valid && out_rdy) begin
      feature_index <= e2_index;
      feature_value <= sat_val;
      last_of_run   <= e2_last;
    end
  end

endmodule

FILE: rtl/stfe_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module stfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/stfe_checker.sv
// Port-level checker for the spike threshold extractor, bound to the top level.
module stfe_checker
  import stfe_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [FIDX_W-1:0]        feature_index,
  input logic signed [FVAL_W-1:0] feature_value,
  input logic                     last_of_run
);

  // Tracks whether a run is open and which feature index must come next.
  logic              in_run;
  logic [FIDX_W-1:0] run_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_run   <= 1'b0;
      run_next <= '0;
    end else if (out_valid && !out_stall) begin
      in_run   <= !last_of_run;
      run_next <= feature_index + FIDX_W'(CHANNELS);
    end
  end

  // A stalled feature beat stays and keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(feature_index)
      && $stable(feature_value) && $stable(last_of_run))
    else $error("stalled feature beat changed or dropped");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("feature beat present right after reset");

  // Only the top level of a run is flagged as its last beat.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_of_run == (feature_index >= LAST_BASE)))
    else $error("last_of_run does not match the feature level");

  // Inside a run each beat is the next level of the same channel; a new run starts at
  // the first level.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (in_run ? (feature_index == run_next)
                          : (feature_index < FIDX_W'(CHANNELS))))
    else $error("feature run broken");

endmodule

bind spike_threshold_feature_extractor_core stfe_checker u_stfe_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .feature_index (feature_index),
  .feature_value (feature_value),
  .last_of_run   (last_of_run)
);
